>>> rtl/core/pwlse_pkg.sv
// ----------------------------------------------------------------------------
// pwlse_pkg: shared types and constants
// Word layouts, register map, field positions, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pwlse_pkg;

   localparam int BIN_W       = 10;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int SEG_COUNT_W = 3;
   localparam int CNT_EXT_W   = SEG_COUNT_W + 1;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 52;
   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_COUNT = 3'd0;
   localparam int REG_SEGMENT_BASE = 1;

   // packed segment word
   localparam int SEG_START_LSB = 42;
   localparam int SEG_END_LSB   = 32;
   localparam int SEG_G1_LSB    = 16;
   localparam int SEG_G2_LSB    = 0;

   // shared multiplier and divider
   localparam int MUL_A_W    = 18;
   localparam int MUL_B_W    = 17;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int NUM_W      = BIN_W + GAIN_W;
   localparam int QUOT_W     = GAIN_W;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int DIV_CNT_W  = 4;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

   typedef struct packed {
      logic [BIN_W-1:0]           bin_index;
      logic signed [SAMPLE_W-1:0] in_real;
      logic signed [SAMPLE_W-1:0] in_imag;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_real;
      logic signed [SAMPLE_W-1:0] out_imag;
      logic [GAIN_W-1:0]          bin_gain;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEG_EVAL,
      ST_INTERP_MUL,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_GAIN_MUL,
      ST_GAIN_ROUND,
      ST_SCALE_RE,
      ST_SCALE_IM,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      MUL_INTERP,
      MUL_GAIN,
      MUL_RE,
      MUL_IM
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        seg_eval;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_load;
      logic        div_step;
      logic        div_done;
      logic        gain_round;
      logic        seg_next;
      logic        res_re_load;
      logic        rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic seg_none;
      logic seg_mid;
      logic seg_last;
      logic div_last;
   } dp_status_type;

endpackage

>>> rtl/core/pwlse_dp.sv
// ----------------------------------------------------------------------------
// pwlse_dp: equalizer datapath
// Segment registers, item registers, one shared 18x17 multiplier, a
// radix-2 restoring divider and the rounding / saturation logic.
// ----------------------------------------------------------------------------
module pwlse_dp #(
   parameter int MAX_SEGMENTS   = 7,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [pwlse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwlse_pkg::CSR_DATA_W-1:0]  csr_data,
   input  pwlse_pkg::req_type                req_data,
   output pwlse_pkg::rsp_type                rsp_data,
   input  pwlse_pkg::dp_cmd_type             cmd,
   output pwlse_pkg::dp_status_type          status
);
   import pwlse_pkg::*;

   localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

   // configuration
   logic [SEG_COUNT_W-1:0] seg_count_ff, seg_count_in;
   logic [CSR_DATA_W-1:0]  seg_ff [MAX_SEGMENTS];
   logic [CSR_DATA_W-1:0]  seg_in [MAX_SEGMENTS];

   // item and working registers
   logic [SEG_IDX_W-1:0]       seg_idx_ff, seg_idx_in;
   logic [BIN_W-1:0]           bin_ff, bin_in;
   logic signed [SAMPLE_W-1:0] re_ff, re_in;
   logic signed [SAMPLE_W-1:0] im_ff, im_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [GAIN_W-1:0]          seg_gain_ff, seg_gain_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]           acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [SAMPLE_W-1:0]        res_re_ff, res_re_in;
   rsp_type                    rsp_ff, rsp_in;

   // segment decode
   logic [CSR_DATA_W-1:0]  seg_word;
   logic [BIN_W-1:0]       seg_start, seg_end, offset, divisor;
   logic [GAIN_W-1:0]      seg_g1, seg_g2;
   logic                   seg_below, seg_above;
   logic signed [GAIN_W:0] delta;
   logic [SEG_COUNT_W-1:0] active_cnt;
   logic [CNT_EXT_W-1:0]   idx_next;

   // arithmetic
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_out;
   logic signed [PROD_W-1:0]  prod_mag;
   logic [BIN_W:0]            div_top, div_trial;
   logic                      div_fits;
   logic [GAIN_W:0]           quot_signed;
   logic [GAIN_W:0]           interp_sum;
   logic signed [PROD_W-1:0]  rnd_sum, rnd_shift;
   logic [GAIN_W-1:0]         gain_sat;
   logic [PROD_W-SAMPLE_W:0]  rnd_hi;
   logic [SAMPLE_W-1:0]       part_sat;

   assign seg_word  = seg_ff[seg_idx_ff];
   assign seg_start = seg_word[SEG_START_LSB +: BIN_W];
   assign seg_end   = seg_word[SEG_END_LSB +: BIN_W];
   assign seg_g1    = seg_word[SEG_G1_LSB +: GAIN_W];
   assign seg_g2    = seg_word[SEG_G2_LSB +: GAIN_W];
   assign seg_below = bin_ff <= seg_start;
   assign seg_above = bin_ff >= seg_end;
   assign delta     = $signed({1'b0, seg_g2}) - $signed({1'b0, seg_g1});
   assign offset    = bin_ff - seg_start;
   assign divisor   = seg_end - seg_start;

   assign active_cnt = (seg_count_ff > SEG_COUNT_W'(MAX_SEGMENTS)) ?
                       SEG_COUNT_W'(MAX_SEGMENTS) : seg_count_ff;
   assign idx_next   = CNT_EXT_W'(seg_idx_ff) + 1'b1;

   assign status.seg_none = active_cnt == '0;
   assign status.seg_mid  = !seg_below && !seg_above;
   assign status.seg_last = idx_next == {1'b0, active_cnt};
   assign status.div_last = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   always_comb begin
      case (cmd.mul_sel)
         MUL_INTERP: begin
            mul_a = MUL_A_W'(delta);
            mul_b = $signed(MUL_B_W'(offset));
         end
         MUL_RE: begin
            mul_a = MUL_A_W'(re_ff);
            mul_b = $signed(MUL_B_W'(gain_ff));
         end
         MUL_IM: begin
            mul_a = MUL_A_W'(im_ff);
            mul_b = $signed(MUL_B_W'(gain_ff));
         end
         default: begin
            mul_a = $signed(MUL_A_W'(gain_ff));
            mul_b = $signed(MUL_B_W'(seg_gain_ff));
         end
      endcase
   end
   assign mul_out = mul_a * mul_b;

   // quotient is known to fit in 16 bits, so only 16 restoring steps are run
   assign prod_mag  = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign div_top   = acc_ff[NUM_W-1 -: BIN_W+1];
   assign div_fits  = div_top >= {1'b0, divisor};
   assign div_trial = div_top - {1'b0, divisor};

   // truncation toward zero: divide magnitudes, then restore the sign
   assign quot_signed = neg_ff ? -{1'b0, acc_ff[QUOT_W-1:0]} : {1'b0, acc_ff[QUOT_W-1:0]};
   assign interp_sum  = {1'b0, seg_g1} + quot_signed;

   // floor((p + half) / 2^F) for either sign
   assign rnd_sum   = prod_ff + $signed(ROUND_HALF);
   assign rnd_shift = rnd_sum >>> GAIN_FRAC_BITS;
   assign gain_sat  = (|rnd_shift[PROD_W-1:GAIN_W]) ? '1 : rnd_shift[GAIN_W-1:0];
   assign rnd_hi    = rnd_shift[PROD_W-1:SAMPLE_W-1];
   assign part_sat  = (&rnd_hi || ~|rnd_hi) ? rnd_shift[SAMPLE_W-1:0] :
                      (rnd_shift[PROD_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

   always_comb begin
      seg_count_in = seg_count_ff;
      seg_in       = seg_ff;
      if (csr_write) begin
         if (csr_index == REG_SEGMENT_COUNT) begin
            seg_count_in = csr_data[SEG_COUNT_W-1:0];
         end
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (csr_index == CSR_INDEX_W'(REG_SEGMENT_BASE + i)) begin
               seg_in[i] = csr_data;
            end
         end
      end
   end

   always_comb begin
      seg_idx_in  = seg_idx_ff;
      bin_in      = bin_ff;
      re_in       = re_ff;
      im_in       = im_ff;
      gain_in     = gain_ff;
      seg_gain_in = seg_gain_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      div_cnt_in  = div_cnt_ff;
      res_re_in   = res_re_ff;
      rsp_in      = rsp_ff;
      if (cmd.load_item) begin
         bin_in     = req_data.bin_index;
         re_in      = req_data.in_real;
         im_in      = req_data.in_imag;
         gain_in    = UNITY_GAIN;
         seg_idx_in = '0;
      end
      if (cmd.seg_eval && !status.seg_mid) begin
         seg_gain_in = seg_below ? seg_g1 : seg_g2;
      end
      if (cmd.mul_en) begin
         prod_in = mul_out;
      end
      if (cmd.div_load) begin
         acc_in     = prod_mag[NUM_W-1:0];
         neg_in     = prod_ff[PROD_W-1];
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         acc_in     = {(div_fits ? div_trial[BIN_W-1:0] : acc_ff[NUM_W-2 -: BIN_W]),
                       acc_ff[QUOT_W-2:0], div_fits};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (cmd.div_done) begin
         seg_gain_in = interp_sum[GAIN_W-1:0];
      end
      if (cmd.gain_round) begin
         gain_in = gain_sat;
      end
      if (cmd.seg_next) begin
         seg_idx_in = seg_idx_ff + 1'b1;
      end
      if (cmd.res_re_load) begin
         res_re_in = part_sat;
      end
      if (cmd.rsp_load) begin
         rsp_in.out_real = res_re_ff;
         rsp_in.out_imag = part_sat;
         rsp_in.bin_gain = gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_ff[i] <= '0;
         end
         seg_idx_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         seg_count_ff <= seg_count_in;
         seg_ff       <= seg_in;
         seg_idx_ff   <= seg_idx_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      gain_ff     <= gain_in;
      seg_gain_ff <= seg_gain_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      res_re_ff   <= res_re_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_div_only_mid: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> status.seg_mid && (divisor != '0))
      else $error("divider started outside the interpolating span");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && status.div_last |=> acc_ff[NUM_W-1 -: BIN_W] < divisor)
      else $error("divider remainder not below divisor");

   a_interp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_done |=> ((seg_gain_ff >= seg_g1) && (seg_gain_ff <= seg_g2)) ||
                       ((seg_gain_ff <= seg_g1) && (seg_gain_ff >= seg_g2)))
      else $error("interpolated gain outside its end gains");

endmodule

>>> rtl/core/pwlse_ctrl.sv
// ----------------------------------------------------------------------------
// pwlse_ctrl: equalizer sequencer
// Walks each word through the active segments, the divider and the two
// scaling multiplies, and owns the output register's valid flag.
// ----------------------------------------------------------------------------
module pwlse_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  pwlse_pkg::dp_status_type status,
   output pwlse_pkg::dp_cmd_type    cmd
);
   import pwlse_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = status.seg_none ? ST_SCALE_RE : ST_SEG_EVAL;
            end
         end
         ST_SEG_EVAL: begin
            cmd.seg_eval = 1'b1;
            state_in     = status.seg_mid ? ST_INTERP_MUL : ST_GAIN_MUL;
         end
         ST_INTERP_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INTERP;
            state_in    = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            cmd.div_done = 1'b1;
            state_in     = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN;
            state_in    = ST_GAIN_ROUND;
         end
         ST_GAIN_ROUND: begin
            cmd.gain_round = 1'b1;
            if (status.seg_last) begin
               state_in = ST_SCALE_RE;
            end else begin
               cmd.seg_next = 1'b1;
               state_in     = ST_SEG_EVAL;
            end
         end
         ST_SCALE_RE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RE;
            state_in    = ST_SCALE_IM;
         end
         ST_SCALE_IM: begin
            cmd.mul_en      = 1'b1;
            cmd.mul_sel     = MUL_IM;
            cmd.res_re_load = 1'b1;
            state_in        = ST_RESULT;
         end
         ST_RESULT: begin
            // wait here only while the previous word is still unclaimed
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("output word overwritten before it was taken");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while one is in progress");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.seg_next |-> !status.seg_last && !status.seg_none)
      else $error("segment index advanced past the active count");

endmodule

>>> rtl/core/piecewise_linear_spectral_equalizer.sv
// ----------------------------------------------------------------------------
// piecewise_linear_spectral_equalizer: top level
// Scales one complex FFT bin per word by the product of up to seven
// piecewise-linear segment gains (unsigned Q4.12).
// ----------------------------------------------------------------------------
// One word is worked on at a time; its result sits in an output register, so
// the next word is taken while that result waits. The time from acceptance to
// the next possible acceptance grows with the number of active segments, and
// most with those at which the bin lies strictly inside the span rather than
// on or outside it, since only those run the bit-serial divider. The single
// shared multiplier serves the interpolation, the gain product and the two
// scaling multiplies in turn. The register writes are always accepted and
// belong in idle periods only; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module piecewise_linear_spectral_equalizer #(
   parameter int MAX_SEGMENTS   = 7,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pwlse_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pwlse_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pwlse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwlse_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pwlse_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   pwlse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pwlse_dp #(
      .MAX_SEGMENTS   (MAX_SEGMENTS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: piecewise_linear_spectral_equalizer
// Drives complex bins through the equaliser under several segment settings
// and checks every result word against an in-bench predictor of the segment
// gains, their rounded product and the saturated scaling.
// ----------------------------------------------------------------------------
module testbench;
   import pwlse_pkg::*;

   localparam int GAIN_FRAC       = 12;
   localparam int SEG_TOTAL       = 7;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RANDOM_PHASES   = 10;
   localparam int WORDS_PER_PHASE = 172;
   localparam int GAIN_CEILING    = 65535;

   class equalizer_scoreboard;
      logic [SEG_COUNT_W-1:0] active_segs;
      logic [CSR_DATA_W-1:0]  seg_word [SEG_TOTAL];
      rsp_type                expected_rsp [$];
      int                     errors;
      int                     checked;

      function new();
         active_segs = '0;
         foreach (seg_word[i]) seg_word[i] = '0;
         errors  = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_SEGMENT_COUNT)
            active_segs = value[SEG_COUNT_W-1:0];
         else if (int'(idx) >= REG_SEGMENT_BASE && int'(idx) < REG_SEGMENT_BASE + SEG_TOTAL)
            seg_word[int'(idx) - REG_SEGMENT_BASE] = value;
      endfunction

      function logic [GAIN_W-1:0] segment_gain(logic [CSR_DATA_W-1:0] w,
                                               logic [BIN_W-1:0] b);
         logic [BIN_W-1:0]  s, e;
         logic [GAIN_W-1:0] g1, g2;
         longint            q;
         s  = w[SEG_START_LSB +: BIN_W];
         e  = w[SEG_END_LSB +: BIN_W];
         g1 = w[SEG_G1_LSB +: GAIN_W];
         g2 = w[SEG_G2_LSB +: GAIN_W];
         if (b <= s) return g1;
         if (b >= e) return g2;
         // signed divide truncates toward zero, as a falling segment needs
         q = ((longint'(g2) - longint'(g1)) * (longint'(b) - longint'(s)))
             / (longint'(e) - longint'(s));
         return GAIN_W'(longint'(g1) + q);
      endfunction

      function logic [SAMPLE_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] x,
                                                 logic [GAIN_W-1:0] g);
         longint p;
         // arithmetic shift gives the floor, so ties round upward
         p = (longint'(x) * longint'(g) + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
         if (p > 32767) p = 32767;
         else if (p < -32768) p = -32768;
         return SAMPLE_W'(p);
      endfunction

      function void note_input(req_type item);
         longint  gain;
         rsp_type r;
         gain = longint'(1) << GAIN_FRAC;
         for (int i = 0; i < int'(active_segs) && i < SEG_TOTAL; i++) begin
            gain = (gain * longint'(segment_gain(seg_word[i], item.bin_index))
                    + (longint'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
            if (gain > GAIN_CEILING) gain = GAIN_CEILING;
         end
         r.out_real = scale_sample(item.in_real, GAIN_W'(gain));
         r.out_imag = scale_sample(item.in_imag, GAIN_W'(gain));
         r.bin_gain = GAIN_W'(gain);
         expected_rsp.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word real %0d imag %0d gain %0h",
                     $time, got.out_real, got.out_imag, got.bin_gain);
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         if (got.out_real !== want.out_real) begin
            errors++;
            $display("%0t: out_real expected %0d, got %0d", $time, want.out_real, got.out_real);
         end
         if (got.out_imag !== want.out_imag) begin
            errors++;
            $display("%0t: out_imag expected %0d, got %0d", $time, want.out_imag, got.out_imag);
         end
         if (got.bin_gain !== want.bin_gain) begin
            errors++;
            $display("%0t: bin_gain expected %0h, got %0h", $time, want.bin_gain, got.bin_gain);
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   bit                     quiet      = 1'b0;
   bit                     req_gaps   = 1'b0;
   bit                     rsp_stalls = 1'b0;
   int                     idle_cycles   = 0;
   int                     words_sent    = 0;
   int                     settings_used = 0;
   logic [CSR_DATA_W-1:0]  next_seg [SEG_TOTAL];
   equalizer_scoreboard    sb = new();

   piecewise_linear_spectral_equalizer #(
      .MAX_SEGMENTS   (SEG_TOTAL),
      .GAIN_FRAC_BITS (GAIN_FRAC)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // all three handshakes are observed here, so the predictor sees them in order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (req_valid && req_ready) sb.note_input(req_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("piecewise_linear_spectral_equalizer verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      wait (!reset);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_stalls && !quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // valid stays high from one word to the next unless a gap is taken
   task automatic send_word(req_type item);
      if (req_gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic load_setting(logic [SEG_COUNT_W-1:0] segs);
      for (int i = 0; i < SEG_TOTAL; i++)
         write_reg(CSR_INDEX_W'(REG_SEGMENT_BASE + i), next_seg[i]);
      write_reg(REG_SEGMENT_COUNT, CSR_DATA_W'(segs));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pack_seg(int s, int e, int g1, int g2);
      return {BIN_W'(s), BIN_W'(e), GAIN_W'(g1), GAIN_W'(g2)};
   endfunction

   function automatic req_type make_word(int bin, int re, int im);
      req_type w;
      w.bin_index = BIN_W'(bin);
      w.in_real   = SAMPLE_W'(re);
      w.in_imag   = SAMPLE_W'(im);
      return w;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'(1);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_seg();
      int          s, e;
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      s   = $urandom_range(0, 1015);
      if ($urandom_range(0, 1)) e = s + $urandom_range(1, 8);
      else e = $urandom_range(s + 1, 1023);
      case ($urandom_range(0, 9))
         0:       return raw[CSR_DATA_W-1:0];
         // start at or after end
         1:       return pack_seg(e, $urandom_range(0, e), $urandom_range(16'h0600, 16'h1C00),
                                  $urandom_range(16'h0600, 16'h1C00));
         2:       return pack_seg(s, e, $urandom_range(0, 1) ? 0 : 16'hFFFF,
                                  $urandom_range(0, 16'hFFFF));
         default: return pack_seg(s, e, $urandom_range(16'h0600, 16'h1C00),
                                  $urandom_range(16'h0600, 16'h1C00));
      endcase
   endfunction

   function automatic req_type random_word();
      req_type               w;
      logic [CSR_DATA_W-1:0] sw;
      w.bin_index = BIN_W'($urandom());
      w.in_real   = SAMPLE_W'($urandom());
      w.in_imag   = SAMPLE_W'($urandom());
      // land on or next to a segment edge now and then
      if ($urandom_range(0, 3) == 0) begin
         sw = sb.seg_word[$urandom_range(0, SEG_TOTAL - 1)];
         w.bin_index = ($urandom_range(0, 1) ? sw[SEG_START_LSB +: BIN_W] : sw[SEG_END_LSB +: BIN_W])
                       + BIN_W'($urandom_range(0, 2)) - BIN_W'(1);
      end
      if ($urandom_range(0, 7) == 0) w.in_real = pick_extreme();
      if ($urandom_range(0, 7) == 0) w.in_imag = pick_extreme();
      return w;
   endfunction

   initial begin
      int                     probe_bins [12];
      logic [SEG_COUNT_W-1:0] segs;
      probe_bins = '{0, 50, 100, 101, 150, 199, 200, 300, 400, 401, 550, 1023};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // straight after reset no segment is active: words pass unchanged
      send_word(make_word(0, 32767, -32768));
      send_word(make_word(1023, -32768, 32767));
      send_word(make_word(512, 0, -1));
      send_word(make_word(1, 1, -1));
      send_word(make_word(1000, 12345, -23456));
      req_valid <= 1'b0;

      // all seven segments: rising, reversed span, falling, full span,
      // adjacent bins and zero-width spans at both ends
      next_seg[0] = pack_seg(100, 200, 16'h1000, 16'h2000);
      next_seg[1] = pack_seg(300, 100, 16'h0800, 16'h1800);
      next_seg[2] = pack_seg(500, 600, 16'hFFFF, 16'h0000);
      next_seg[3] = pack_seg(0, 1023, 16'h0000, 16'h4000);
      next_seg[4] = pack_seg(400, 401, 16'h1800, 16'h0C00);
      next_seg[5] = pack_seg(1023, 1023, 16'h1000, 16'hFFFF);
      next_seg[6] = pack_seg(0, 0, 16'hFFFF, 16'h1000);
      drain();
      load_setting(SEG_COUNT_W'(7));
      foreach (probe_bins[i])
         send_word(make_word(probe_bins[i], 20000 - i * 3000, -32768 + i * 5000));
      req_valid <= 1'b0;

      // maximal gains: the product saturates, and both parts do for full-scale inputs
      foreach (next_seg[i]) next_seg[i] = pack_seg(0, 0, 16'hFFFF, 16'hFFFF);
      drain();
      load_setting(SEG_COUNT_W'(3));
      send_word(make_word(0, 32767, -32768));
      send_word(make_word(700, -1, 1));
      send_word(make_word(5, -32768, 32767));
      req_valid <= 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiet = (p >= RANDOM_PHASES - 2);
         foreach (next_seg[i]) next_seg[i] = random_seg();
         if (p == 0) segs = SEG_COUNT_W'(7);
         else if (p == 1) segs = '0;
         else if (p == 2) segs = SEG_COUNT_W'(1);
         else segs = SEG_COUNT_W'($urandom_range(0, 7));
         drain();
         load_setting(segs);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n % 43 == 0) begin
               req_gaps   = ($urandom_range(0, 2) != 0);
               rsp_stalls = ($urandom_range(0, 2) != 0);
            end
            send_word(random_word());
         end
         req_valid <= 1'b0;
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d bin words under %0d segment settings, %0d result words compared.",
               words_sent, settings_used, sb.checked);
      $display("Settings ranged from no active segment to all seven, with saturating gains.");
      if (sb.errors == 0) begin
         $display("piecewise_linear_spectral_equalizer verification clean");
      end else begin
         $display("piecewise_linear_spectral_equalizer verification failed");
      end
      $finish;
   end

endmodule
